[sv/planar_rigid_coordinate_transform_core_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef PLANAR_RIGID_COORDINATE_TRANSFORM_CORE_MACROS_SVH
`define PLANAR_RIGID_COORDINATE_TRANSFORM_CORE_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define PRCT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PRCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/prct_pkg.sv]
// Shared types, constants and tables of the planar rigid transform core.
`timescale 1ns / 1ps
package prct_pkg;

  localparam int COORD_W         = 32;
  localparam int ANGLE_W         = 26;
  localparam int OANG_W          = 27;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int HALF_TURN_DEG   = 180;
  localparam int FULL_TURN       = (2 * HALF_TURN_DEG) << ANGLE_FRAC_BITS;
  localparam int RED_W           = ANGLE_W + 2;

  // full turn = 45 * 2^(ANGLE_FRAC_BITS+3)
  localparam int TURN_DIV        = (2 * HALF_TURN_DEG) / 8;
  localparam int R_W             = ANGLE_FRAC_BITS + 9;
  localparam int Q_W             = ANGLE_FRAC_BITS + 3;
  localparam int BAM_SHIFT       = 29 - ANGLE_FRAC_BITS;
  localparam int BAM_W           = 32;
  localparam int MAGIC_K         = R_W + 6;
  localparam longint MAGIC_M     = ((64'sd1 << MAGIC_K) + TURN_DIV - 1) / TURN_DIV;
  localparam int MAGIC_W         = R_W + 2;
  localparam int M_W             = 6;

  localparam int P_W             = COORD_W + 1;
  localparam int TRIG_W          = 33;
  localparam int Z_W             = 34;
  localparam int MAX_STAGES      = 28;
  localparam int DEF_CORDIC_STAGES = 18;
  localparam int CORDIC_X0       = 652032874;
  localparam int ROUND_SHIFT     = 30;

  typedef struct packed {
    logic signed [P_W-1:0]     px;
    logic signed [P_W-1:0]     py;
    logic signed [COORD_W-1:0] add_x;
    logic signed [COORD_W-1:0] add_y;
    logic                      neg_x;
    logic                      neg_y;
    logic                      neg_s;
    logic signed [OANG_W-1:0]  angle;
  } ctx_t;

  // Arctangent of 2^-i in binary-angle units (one turn = 2^32).
  function automatic logic [BAM_W-1:0] atan_bam(input int i);
    logic [BAM_W-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/prct_angle_prep.sv]
// Front end: point/offset setup and frame angle to binary angle, three stages.
`timescale 1ns / 1ps
module prct_angle_prep (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic signed [prct_pkg::COORD_W-1:0] in_x,
  input  logic signed [prct_pkg::COORD_W-1:0] in_y,
  input  logic signed [prct_pkg::ANGLE_W-1:0] in_angle,
  input  logic signed [prct_pkg::COORD_W-1:0] offset_x,
  input  logic signed [prct_pkg::COORD_W-1:0] offset_y,
  input  logic signed [prct_pkg::ANGLE_W-1:0] offset_angle,
  input  logic [1:0]                          axis_type,
  input  logic                               to_global,
  output logic                               out_valid,
  input  logic                               out_ready,
  output prct_pkg::ctx_t                     out_ctx,
  output logic signed [prct_pkg::Z_W-1:0]     out_z,
  output logic                               out_flip
);
  import prct_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;

  ctx_t ctx1, ctx2, ctx3;
  logic [R_W-1:0] r1, r2;
  logic [Q_W-1:0] q2;
  logic signed [Z_W-1:0] z3;
  logic flip3;

  logic [BAM_SHIFT-1:0] frac_lut [0:(1<<M_W)-1];

  logic signed [RED_W-1:0] deg, t0, t1, t2;
  logic signed [P_W-1:0] xe, ye, oxe, oye;
  logic class0, neg_x, neg_y, neg_s;
  ctx_t ctx_next;
  logic [R_W+MAGIC_W-1:0] prod;
  logic [R_W-1:0] m_full;
  logic [BAM_W-1:0] bam, bam_f;
  logic flip;

  for (genvar gi = 0; gi < (1 << M_W); gi++) begin : g_lut
    assign frac_lut[gi] = BAM_SHIFT'((gi * (1 << BAM_SHIFT) + TURN_DIV / 2) / TURN_DIV);
  end

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: reduce the frame angle into one turn, set up the point.
  always_comb begin
    deg = RED_W'(offset_angle);
    t0  = (deg < 0) ? deg + RED_W'(FULL_TURN) : deg;
    t1  = (t0 < 0) ? t0 + RED_W'(FULL_TURN) : t0;
    t2  = (t1 >= RED_W'(FULL_TURN)) ? t1 - RED_W'(FULL_TURN) : t1;

    class0 = req_type || !axis_type[1];
    neg_x  = req_type && axis_type[0];
    neg_y  = req_type && (axis_type == 2'd0 || axis_type == 2'd3);
    neg_s  = (class0 == to_global);

    xe  = {in_x[COORD_W-1], in_x};
    ye  = {in_y[COORD_W-1], in_y};
    oxe = {offset_x[COORD_W-1], offset_x};
    oye = {offset_y[COORD_W-1], offset_y};

    if (to_global) begin
      ctx_next.px    = neg_x ? -xe : xe;
      ctx_next.py    = neg_y ? -ye : ye;
      ctx_next.add_x = offset_x;
      ctx_next.add_y = offset_y;
      ctx_next.angle = OANG_W'(in_angle) + OANG_W'(offset_angle);
    end else begin
      ctx_next.px    = xe - oxe;
      ctx_next.py    = ye - oye;
      ctx_next.add_x = '0;
      ctx_next.add_y = '0;
      ctx_next.angle = OANG_W'(in_angle) - OANG_W'(offset_angle);
    end
    ctx_next.neg_x = neg_x && !to_global;
    ctx_next.neg_y = neg_y && !to_global;
    ctx_next.neg_s = neg_s;
  end

  // Stage 2: quotient by 45 through a reciprocal multiply.
  assign prod = (R_W+MAGIC_W)'(r1) * (R_W+MAGIC_W)'(MAGIC_W'(MAGIC_M));

  // Stage 3: remainder, fraction table, half-turn fold.
  always_comb begin
    m_full = r2 - R_W'(q2 * R_W'(TURN_DIV));
    bam    = {q2, frac_lut[m_full[M_W-1:0]]};
    flip   = bam[BAM_W-1] ^ bam[BAM_W-2];
    bam_f  = {bam[BAM_W-1] ^ flip, bam[BAM_W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctx1 <= ctx_next;
      r1   <= R_W'(t2);
    end
    if (en2) begin
      ctx2 <= ctx1;
      r2   <= r1;
      q2   <= Q_W'(prod >> MAGIC_K);
    end
    if (en3) begin
      ctx3  <= ctx2;
      z3    <= Z_W'($signed(bam_f));
      flip3 <= flip;
    end
  end

  assign out_valid = v3;
  assign out_ctx   = ctx3;
  assign out_z     = z3;
  assign out_flip  = flip3;

endmodule

[sv/prct_cordic.sv]
// Rotation-mode CORDIC, one register stage per iteration.
`timescale 1ns / 1ps
module prct_cordic #(
  parameter int CORDIC_STAGES = prct_pkg::DEF_CORDIC_STAGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  prct_pkg::ctx_t                    in_ctx,
  input  logic signed [prct_pkg::Z_W-1:0]    in_z,
  input  logic                              in_flip,
  output logic                              out_valid,
  input  logic                              out_ready,
  output prct_pkg::ctx_t                    out_ctx,
  output logic signed [prct_pkg::TRIG_W-1:0] out_cos,
  output logic signed [prct_pkg::TRIG_W-1:0] out_sin,
  output logic                              out_flip
);
  import prct_pkg::*;

  logic                     v    [0:CORDIC_STAGES-1];
  logic                     en   [0:CORDIC_STAGES];
  logic signed [TRIG_W-1:0] xr   [0:CORDIC_STAGES-1];
  logic signed [TRIG_W-1:0] yr   [0:CORDIC_STAGES-1];
  logic signed [Z_W-1:0]    zr   [0:CORDIC_STAGES-1];
  ctx_t                     cr   [0:CORDIC_STAGES-1];
  logic                     fr   [0:CORDIC_STAGES-1];

  assign en[CORDIC_STAGES] = out_ready;
  assign in_ready = en[0];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic                     vi;
    logic signed [TRIG_W-1:0] xi, yi, xs, ys;
    logic signed [Z_W-1:0]    zi;
    ctx_t                     ci;
    logic                     fi;
    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_bam(k));

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = TRIG_W'(CORDIC_X0);
      assign yi = '0;
      assign zi = in_z;
      assign ci = in_ctx;
      assign fi = in_flip;
    end else begin : g_next
      assign vi = v[k-1];
      assign xi = xr[k-1];
      assign yi = yr[k-1];
      assign zi = zr[k-1];
      assign ci = cr[k-1];
      assign fi = fr[k-1];
    end

    assign en[k] = !v[k] || en[k+1];
    assign xs = xi >>> k;
    assign ys = yi >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= vi;
      end
    end

    // Turn toward zero residual angle; zero counts as positive.
    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (zi >= 0) begin
          xr[k] <= xi - ys;
          yr[k] <= yi + xs;
          zr[k] <= zi - ATAN;
        end else begin
          xr[k] <= xi + ys;
          yr[k] <= yi - xs;
          zr[k] <= zi + ATAN;
        end
        cr[k] <= ci;
        fr[k] <= fi;
      end
    end
  end

  assign out_valid = v[CORDIC_STAGES-1];
  assign out_ctx   = cr[CORDIC_STAGES-1];
  assign out_cos   = xr[CORDIC_STAGES-1];
  assign out_sin   = yr[CORDIC_STAGES-1];
  assign out_flip  = fr[CORDIC_STAGES-1];

endmodule

[sv/prct_rotate.sv]
// Back end: products, rounded sums, offset, flips and saturation.
`timescale 1ns / 1ps
module prct_rotate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  prct_pkg::ctx_t                     in_ctx,
  input  logic signed [prct_pkg::TRIG_W-1:0]  in_cos,
  input  logic signed [prct_pkg::TRIG_W-1:0]  in_sin,
  input  logic                               in_flip,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [prct_pkg::COORD_W-1:0] out_x,
  output logic signed [prct_pkg::COORD_W-1:0] out_y,
  output logic signed [prct_pkg::OANG_W-1:0]  out_angle
);
  import prct_pkg::*;

  localparam int PR_W  = P_W + TRIG_W;
  localparam int SUM_W = PR_W + 1;
  localparam int RND_W = SUM_W - ROUND_SHIFT;
  localparam int FIN_W = RND_W + 2;

  logic v1, v2, v3;
  logic en1, en2, en3;

  ctx_t ctx1, ctx2;
  logic signed [PR_W-1:0]  p_xc, p_ys, p_xs, p_yc;
  logic signed [RND_W-1:0] rx2, ry2;
  logic signed [COORD_W-1:0] ox3, oy3;
  logic signed [OANG_W-1:0]  ang3;

  logic signed [TRIG_W-1:0] c, s;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [FIN_W-1:0]  fx, fy;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [FIN_W-1:0] v);
    logic signed [FIN_W-1:0] hi, lo;
    hi = FIN_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - FIN_W'(1);
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // Undo the half-turn fold and apply the handedness sign to sine.
  always_comb begin
    c = in_flip ? -in_cos : in_cos;
    s = (in_flip ^ in_ctx.neg_s) ? -in_sin : in_sin;
  end

  // Round half up, then scale back from Q30.
  always_comb begin
    sx = SUM_W'(p_xc) - SUM_W'(p_ys) + (SUM_W'(1) <<< (ROUND_SHIFT - 1));
    sy = SUM_W'(p_xs) + SUM_W'(p_yc) + (SUM_W'(1) <<< (ROUND_SHIFT - 1));
  end

  always_comb begin
    fx = FIN_W'(rx2) + FIN_W'(ctx2.add_x);
    fy = FIN_W'(ry2) + FIN_W'(ctx2.add_y);
    if (ctx2.neg_x) fx = -fx;
    if (ctx2.neg_y) fy = -fy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctx1 <= in_ctx;
      p_xc <= PR_W'(in_ctx.px) * PR_W'(c);
      p_ys <= PR_W'(in_ctx.py) * PR_W'(s);
      p_xs <= PR_W'(in_ctx.px) * PR_W'(s);
      p_yc <= PR_W'(in_ctx.py) * PR_W'(c);
    end
    if (en2) begin
      ctx2 <= ctx1;
      rx2  <= RND_W'(sx >>> ROUND_SHIFT);
      ry2  <= RND_W'(sy >>> ROUND_SHIFT);
    end
    if (en3) begin
      ox3  <= sat(fx);
      oy3  <= sat(fy);
      ang3 <= ctx2.angle;
    end
  end

  assign out_valid = v3;
  assign out_x     = ox3;
  assign out_y     = oy3;
  assign out_angle = ang3;

endmodule

[sv/planar_rigid_coordinate_transform_core.sv]
// Top level of the planar rigid coordinate transform core.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready) takes one item per cycle while
//   in_ready is high: a point, its angle, a frame offset and rotation,
//   axis type, direction and mode. Output channel (out_valid/out_ready)
//   returns one item per input item, in order: saturated out_x/out_y and
//   the unwrapped out_angle.
// Stages and rate
//   Three front stages (angle reduction, divide by 45, binary-angle fold),
//   one stage per CORDIC iteration, three back stages (four 33x33 products,
//   rounded sums, offset/flip/saturate). Throughput is one item per cycle
//   while out_ready is high; the four product multipliers and the CORDIC
//   adders are each used once per item.
// Reset
//   Synchronous rst clears every valid bit; data registers are not cleared.
// Stall
//   Each stage holds while the next is full and not moving, so bubbles
//   close up; in_ready drops only once every stage holds an item.
module planar_rigid_coordinate_transform_core #(
  parameter int CORDIC_STAGES = prct_pkg::DEF_CORDIC_STAGES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic signed [prct_pkg::COORD_W-1:0] in_x,
  input  logic signed [prct_pkg::COORD_W-1:0] in_y,
  input  logic signed [prct_pkg::ANGLE_W-1:0] in_angle,
  input  logic signed [prct_pkg::COORD_W-1:0] offset_x,
  input  logic signed [prct_pkg::COORD_W-1:0] offset_y,
  input  logic signed [prct_pkg::ANGLE_W-1:0] offset_angle,
  input  logic [1:0]                          axis_type,
  input  logic                               to_global,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [prct_pkg::COORD_W-1:0] out_x,
  output logic signed [prct_pkg::COORD_W-1:0] out_y,
  output logic signed [prct_pkg::OANG_W-1:0]  out_angle
);
  import prct_pkg::*;

  // Front end to CORDIC.
  logic                  pre_valid, pre_ready;
  ctx_t                  pre_ctx;
  logic signed [Z_W-1:0] pre_z;
  logic                  pre_flip;

  // CORDIC to back end.
  logic                     cor_valid, cor_ready;
  ctx_t                     cor_ctx;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;
  logic                     cor_flip;

  prct_angle_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_angle     (in_angle),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .offset_angle (offset_angle),
    .axis_type    (axis_type),
    .to_global    (to_global),
    .out_valid    (pre_valid),
    .out_ready    (pre_ready),
    .out_ctx      (pre_ctx),
    .out_z        (pre_z),
    .out_flip     (pre_flip)
  );

  // Sine and cosine of the half-turn-folded frame rotation, Q30, gain already applied.
  prct_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_ctx    (pre_ctx),
    .in_z      (pre_z),
    .in_flip   (pre_flip),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_ctx   (cor_ctx),
    .out_cos   (cor_cos),
    .out_sin   (cor_sin),
    .out_flip  (cor_flip)
  );

  // Last stage doubles as the output register.
  prct_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_ctx    (cor_ctx),
    .in_cos    (cor_cos),
    .in_sin    (cor_sin),
    .in_flip   (cor_flip),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_angle (out_angle)
  );

endmodule

[sv/prct_checker.sv]
// Port-level checker for the transform core, bound to the top level.
`timescale 1ns / 1ps
`include "planar_rigid_coordinate_transform_core_macros.svh"
module prct_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [prct_pkg::COORD_W-1:0] out_x,
  input logic signed [prct_pkg::COORD_W-1:0] out_y,
  input logic signed [prct_pkg::OANG_W-1:0]  out_angle
);
  import prct_pkg::*;

  `PRCT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")
  `PRCT_ASSERT(a_empty_ready, clk, rst, !out_valid |-> in_ready, "empty core refused an item")
  `PRCT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `PRCT_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_angle), "stalled result changed")

endmodule

bind planar_rigid_coordinate_transform_core prct_checker u_prct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_angle (out_angle)
);

[tb/tb_planar_rigid_coordinate_transform_core.sv]
// Self-checking testbench for the planar rigid coordinate transform core.
`timescale 1ns / 1ps
module tb_planar_rigid_coordinate_transform_core;
  import prct_pkg::*;

  // axis types, modes and directions of one item
  localparam logic [1:0] AXIS_LEFT_UP    = 2'd0;
  localparam logic [1:0] AXIS_RIGHT_DOWN = 2'd1;
  localparam logic [1:0] AXIS_LEFT_DOWN  = 2'd2;
  localparam logic [1:0] AXIS_RIGHT_UP   = 2'd3;
  localparam logic       MODE_PLAIN      = 1'b0;
  localparam logic       MODE_MOUNT      = 1'b1;
  localparam logic       DIR_TO_LOCAL    = 1'b0;
  localparam logic       DIR_TO_GLOBAL   = 1'b1;
  localparam longint     DEG             = 64'sd1 << ANGLE_FRAC_BITS;
  localparam int         STAGES          = DEF_CORDIC_STAGES;
  localparam int         LATENCY         = STAGES + 6;

  typedef struct {
    logic                      req_type;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [ANGLE_W-1:0] oangle;
    logic [1:0]                axis;
    logic                      dir;
  } point_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [OANG_W-1:0]  angle;
  } point_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic signed [COORD_W-1:0] in_x = '0, in_y = '0, offset_x = '0, offset_y = '0;
  logic signed [ANGLE_W-1:0] in_angle = '0, offset_angle = '0;
  logic [1:0] axis_type = '0;
  logic to_global = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_x, out_y;
  logic signed [OANG_W-1:0]  out_angle;

  point_req_t pending_points[$];
  point_res_t expected_points[$];
  point_req_t cur_point;
  logic in_took = 1'b0;
  logic stim_done = 1'b0;
  int   burst_left = 0, gap_left = 0;
  int   mismatches = 0;
  int   rx_cycle = 0, rx_mode = 0;

  planar_rigid_coordinate_transform_core i_dut (
    .clk, .rst, .in_valid, .in_ready, .req_type, .in_x, .in_y, .in_angle,
    .offset_x, .offset_y, .offset_angle, .axis_type, .to_global,
    .out_valid, .out_ready, .out_x, .out_y, .out_angle
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Q30 cosine and sine of a frame angle through the fixed-stage CORDIC
  function automatic void rotor(input longint deg, output longint c, output longint s);
    longint full, r, xv, yv, z, xs, ys;
    longint unsigned q;
    logic [31:0] bam;
    logic fold;
    full = 360 * DEG;
    r = deg % full;
    if (r < 0) r += full;
    q = ((longint'(r) << 32) + full / 2) / full;
    bam = q[31:0];
    fold = ((bam + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (fold) bam = bam + 32'h8000_0000;
    z = longint'($signed(bam));
    xv = CORDIC_X0;
    yv = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (z >= 0) begin
        xv -= ys; yv += xs; z -= longint'(atan_bam(i));
      end else begin
        xv += ys; yv -= xs; z += longint'(atan_bam(i));
      end
    end
    c = fold ? -xv : xv;
    s = fold ? -yv : yv;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic point_res_t transform_point(input point_req_t p);
    point_res_t res;
    logic flip_x, flip_y, right_handed, pos_s;
    longint c, s, px, py, rx, ry;
    flip_x = 1'b0;
    flip_y = 1'b0;
    if (p.req_type == MODE_MOUNT) begin
      right_handed = 1'b1;
      flip_x = (p.axis == AXIS_RIGHT_DOWN) || (p.axis == AXIS_RIGHT_UP);
      flip_y = (p.axis == AXIS_LEFT_UP) || (p.axis == AXIS_RIGHT_UP);
    end else begin
      right_handed = (p.axis == AXIS_LEFT_UP) || (p.axis == AXIS_RIGHT_DOWN);
    end
    rotor(longint'(p.oangle), c, s);
    pos_s = right_handed != (p.dir == DIR_TO_GLOBAL);
    if (!pos_s) s = -s;
    if (p.dir == DIR_TO_GLOBAL) begin
      px = flip_x ? -longint'(p.x) : longint'(p.x);
      py = flip_y ? -longint'(p.y) : longint'(p.y);
    end else begin
      px = longint'(p.x) - longint'(p.ox);
      py = longint'(p.y) - longint'(p.oy);
    end
    rx = (px * c - py * s + (64'sd1 << 29)) >>> ROUND_SHIFT;
    ry = (px * s + py * c + (64'sd1 << 29)) >>> ROUND_SHIFT;
    if (p.dir == DIR_TO_GLOBAL) begin
      rx += longint'(p.ox);
      ry += longint'(p.oy);
      res.angle = OANG_W'(longint'(p.angle) + longint'(p.oangle));
    end else begin
      if (flip_x) rx = -rx;
      if (flip_y) ry = -ry;
      res.angle = OANG_W'(longint'(p.angle) - longint'(p.oangle));
    end
    res.x = COORD_W'(clamp32(rx));
    res.y = COORD_W'(clamp32(ry));
    return res;
  endfunction

  // coordinate: mostly moderate, sometimes full range or an extreme
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2:    return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 * 2000)) - 2000) <<< 16
                      | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return ANGLE_W'($urandom());
      1: return ANGLE_W'(longint'($urandom_range(0, 8)) * 45 * DEG - 180 * DEG);
      default: return ANGLE_W'(longint'($urandom_range(0, 2 * 23592960)) - 23592960);
    endcase
  endfunction

  task automatic add_point(input logic mode, input logic [31:0] x, input logic [31:0] y,
                           input longint ang, input logic [31:0] ox,
                           input logic [31:0] oy, input longint oang,
                           input logic [1:0] axis, input logic dir);
    point_req_t p;
    p.req_type = mode; p.x = x; p.y = y; p.angle = ANGLE_W'(ang);
    p.ox = ox; p.oy = oy; p.oangle = ANGLE_W'(oang); p.axis = axis; p.dir = dir;
    pending_points.push_back(p);
  endtask

  // Fill the item queue: directed corners first, then random items.
  initial begin
    // every mode, axis type and direction at thirty degrees
    for (int k = 0; k < 16; k++)
      add_point(k[3], 32'sd5 << 16, -(32'sd3 << 16), 10 * DEG, 32'sd1 << 16,
                32'sd2 << 16, 30 * DEG, k[1:0], k[2]);
    // quadrant edges of the frame angle, wrap past a full turn, field extremes
    add_point(MODE_PLAIN, 32'sd100 << 16, 32'sd0, 0, 0, 0, 90 * DEG, AXIS_LEFT_UP,
              DIR_TO_GLOBAL);
    add_point(MODE_PLAIN, 32'sd100 << 16, 32'sd7, 0, 0, 0, 270 * DEG, AXIS_LEFT_DOWN,
              DIR_TO_LOCAL);
    add_point(MODE_PLAIN, 32'sd100 << 16, 32'sd7, 0, 0, 0, -180 * DEG, AXIS_RIGHT_UP,
              DIR_TO_GLOBAL);
    add_point(MODE_MOUNT, 32'sd9, 32'sd100 << 16, 360 * DEG, 0, 0, 360 * DEG,
              AXIS_RIGHT_UP, DIR_TO_LOCAL);
    add_point(MODE_PLAIN, 32'h7fff_ffff, 32'h7fff_ffff, 33554431, 32'h8000_0000,
              32'h8000_0000, 33554431, AXIS_RIGHT_DOWN, DIR_TO_LOCAL);
    add_point(MODE_PLAIN, 32'h8000_0000, 32'h8000_0000, -33554432, 32'h7fff_ffff,
              32'h7fff_ffff, -33554432, AXIS_LEFT_UP, DIR_TO_LOCAL);
    add_point(MODE_MOUNT, 32'h8000_0000, 32'h7fff_ffff, 23592960, 32'h7fff_ffff,
              32'h8000_0000, -23592960, AXIS_RIGHT_UP, DIR_TO_GLOBAL);
    add_point(MODE_MOUNT, 32'h7fff_ffff, 32'h8000_0000, -23592960, 32'h8000_0000,
              32'h7fff_ffff, 45 * DEG, AXIS_LEFT_DOWN, DIR_TO_GLOBAL);
    for (int n = 0; n < 1900; n++)
      add_point(1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                longint'($signed(pick_angle())),
                pick_coord(), pick_coord(), longint'($signed(pick_angle())),
                2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    stim_done = 1'b1;
  end

  // Record the item accepted at this edge and queue its expected result.
  always @(posedge clk) begin
    in_took <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) expected_points.push_back(transform_point(cur_point));
  end

  // Sender: hold an item until taken, else advance in bursts with gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        cur_point = pending_points.pop_front();
        in_valid <= 1'b1;
        req_type <= cur_point.req_type;
        in_x <= cur_point.x;
        in_y <= cur_point.y;
        in_angle <= cur_point.angle;
        offset_x <= cur_point.ox;
        offset_y <= cur_point.oy;
        offset_angle <= cur_point.oangle;
        axis_type <= cur_point.axis;
        to_global <= cur_point.dir;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between random stall patterns, from always ready to rarely ready.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 5) != 0;
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each taken result with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d angle=%0d", out_x, out_y, out_angle);
      end else begin
        point_res_t e;
        e = expected_points.pop_front();
        if (e.x !== out_x || e.y !== out_y || e.angle !== out_angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d angle=%0d, got x=%0d y=%0d angle=%0d",
                     e.x, e.y, e.angle, out_x, out_y, out_angle);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    wait (pending_points.size() == 0 && !in_valid);
    wait (expected_points.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/prct_pkg.sv
sv/prct_angle_prep.sv
sv/prct_cordic.sv
sv/prct_rotate.sv
sv/planar_rigid_coordinate_transform_core.sv
sv/prct_checker.sv
tb/tb_planar_rigid_coordinate_transform_core.sv
